/* hdl/lfsr_range_shuffle_unit_assert.svh */
// assertion macros shared by the shuffle unit modules
// expects signals clk and arst_n in the including module
`ifndef LFSR_RANGE_SHUFFLE_UNIT_ASSERT_SVH
`define LFSR_RANGE_SHUFFLE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define LRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lrs_pkg.sv */
// shared types, constants and tap table for the lfsr range shuffle unit
// no dependencies
package lrs_pkg;

	localparam int MAX_BITS   = 32;
	localparam int DATA_W     = 32;
	localparam int EXP_W      = 5;
	localparam int SKIP_LIMIT = 256;
	localparam int SKIP_CNT_W = $clog2(SKIP_LIMIT);
	localparam int CFG_IDX_W  = 1;

	localparam logic [DATA_W-1:0] SEED_RESET = 32'hABCD_EFED;

	// tap masks per width exponent, each gives a full-period sequence
	localparam logic [7:0] TAP_TABLE [32] = '{
		8'd1,  8'd3,  8'd3,  8'd3,  8'd5,  8'd3,  8'd3,  8'd29,
		8'd17, 8'd9,  8'd5,  8'd83, 8'd27, 8'd43, 8'd3,  8'd45,
		8'd9,  8'd129, 8'd39, 8'd9, 8'd5,  8'd3,  8'd33, 8'd27,
		8'd9,  8'd71, 8'd39, 8'd9,  8'd5,  8'd83, 8'd9,  8'd197
	};

	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_NEXT    = 2'd1,
		OP_RESTORE = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_SIZE = 1'b0,
		REG_SEED_VALUE = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_FIND,
		S_SEED,
		S_SKIP,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [DATA_W-1:0] restore_value;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] number;
		logic              cycle_done;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic start_clr;
		logic find;
		logic seed;
		logic skip;
		logic restore;
		logic next_mode;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic range_zero;
		logic active_zero;
		logic seed_above;
		logic skip_last;
		logic out_free;
	} status_t;

endpackage

/* hdl/lrs_ctrl.sv */
// sequencing state machine for the lfsr range shuffle unit
// depends on lrs_pkg and lfsr_range_shuffle_unit_assert.svh
`include "lfsr_range_shuffle_unit_assert.svh"

module lrs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [1:0]       opcode,
	input  lrs_pkg::status_t status,
	output lrs_pkg::cmd_t    cmd
);
	import lrs_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_START;
		end else begin
			state_q <= state_d;
			if (req_valid && req_ready) begin
				op_q <= opcode;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		req_ready     = 1'b0;
		cmd           = '0;
		cmd.restore   = (op_q == OP_RESTORE);
		cmd.next_mode = (op_q == OP_NEXT);
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					if (opcode == OP_START || opcode == OP_RESTORE) begin
						state_d = S_START;
					end else if (opcode == OP_NEXT && !status.active_zero) begin
						state_d = S_SKIP;
					end else begin
						state_d = S_RESULT;
					end
				end
			end
			S_START: begin
				cmd.start_clr = 1'b1;
				state_d = status.range_zero ? S_RESULT : S_FIND;
			end
			S_FIND: begin
				cmd.find = 1'b1;
				state_d  = S_SEED;
			end
			S_SEED: begin
				cmd.seed = 1'b1;
				state_d  = status.seed_above ? S_SKIP : S_RESULT;
			end
			S_SKIP: begin
				cmd.skip = 1'b1;
				if (status.skip_last) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`LRS_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_q != S_IDLE, "accepted request did not start work")
	`LRS_ASSERT_NOW(a_seed_after_find, state_q == S_SEED, $past(state_q) == S_FIND, "seed step not preceded by width search")
	`LRS_ASSERT_NEXT(a_find_after_nonzero, state_q == S_START && !status.range_zero, state_q == S_FIND, "nonzero size start skipped width search")

endmodule

/* hdl/lrs_datapath.sv */
// registers, lfsr step logic and result register of the shuffle unit
// depends on lrs_pkg and lfsr_range_shuffle_unit_assert.svh
`include "lfsr_range_shuffle_unit_assert.svh"

module lrs_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrs_pkg::cmd_t                 cmd,
	output lrs_pkg::status_t              status,
	input  lrs_pkg::req_t                 req,
	input  logic                          cfg_we,
	input  logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lrs_pkg::DATA_W-1:0]    cfg_data,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output lrs_pkg::rsp_t                 rsp
);
	import lrs_pkg::*;

	logic [DATA_W-1:0]     range_size_q, seed_q;
	logic [DATA_W-1:0]     lfsr_q, start_q, size_q, hold_q, rv_q;
	logic [EXP_W-1:0]      exp_q;
	logic                  wrapped_q;
	logic [SKIP_CNT_W-1:0] cnt_q;
	logic                  out_valid_q;
	rsp_t                  rsp_q;

	logic [DATA_W-1:0] adv, seeded, masked, top_bit;
	logic [7:0]        tap;
	logic [EXP_W-1:0]  exp_found;

	// one galois step at the current width
	always_comb begin
		tap     = TAP_TABLE[exp_q];
		top_bit = DATA_W'(1) << exp_q;
		if (lfsr_q[0]) begin
			adv = ((lfsr_q ^ DATA_W'(tap)) >> 1) | top_bit;
		end else begin
			adv = lfsr_q >> 1;
		end
	end

	// highest set bit of the latched size, limited to the widest lfsr
	always_comb begin
		exp_found = '0;
		for (int i = 1; i < DATA_W; i++) begin
			if (size_q[i]) begin
				exp_found = EXP_W'(i);
			end
		end
		if (exp_found > EXP_W'(MAX_BITS - 1)) begin
			exp_found = EXP_W'(MAX_BITS - 1);
		end
	end

	// seed, zero taken as one, masked to exp+1 bits
	always_comb begin
		seeded = (seed_q == '0) ? DATA_W'(1) : seed_q;
		masked = seeded & ~({{(DATA_W-1){1'b1}}, 1'b0} << exp_q);
	end

	always_comb begin
		status.range_zero  = (range_size_q == '0);
		status.active_zero = (size_q == '0);
		status.seed_above  = (masked > size_q);
		status.skip_last   = (adv <= size_q) || (cnt_q == SKIP_CNT_W'(SKIP_LIMIT - 1));
		status.out_free    = !out_valid_q || rsp_ready;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_size_q <= '0;
			seed_q       <= SEED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_SIZE: range_size_q <= cfg_data;
				REG_SEED_VALUE: seed_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q    <= DATA_W'(1);
			start_q   <= DATA_W'(1);
			size_q    <= '0;
			exp_q     <= '0;
			wrapped_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cmd.capture) begin
				cnt_q <= '0;
			end
			if (cmd.start_clr) begin
				wrapped_q <= 1'b0;
				if (!status.range_zero) begin
					size_q <= range_size_q;
				end else if (cmd.restore) begin
					lfsr_q <= rv_q;
				end
			end
			if (cmd.find) begin
				exp_q <= exp_found;
			end
			if (cmd.seed) begin
				cnt_q <= '0;
				if (status.seed_above) begin
					lfsr_q <= masked;
				end else begin
					start_q <= masked;
					lfsr_q  <= cmd.restore ? rv_q : masked;
				end
			end
			if (cmd.skip) begin
				cnt_q <= cnt_q + SKIP_CNT_W'(1);
				if (!status.skip_last) begin
					lfsr_q <= adv;
				end else if (cmd.next_mode) begin
					lfsr_q <= adv;
					if (adv == start_q) begin
						wrapped_q <= 1'b1;
					end
				end else begin
					start_q <= adv;
					lfsr_q  <= cmd.restore ? rv_q : adv;
				end
			end
		end
	end

	// holding registers for the lfsr value and the restore payload, loaded when a request is taken
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hold_q <= lfsr_q;
			rv_q   <= req.restore_value;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.number     <= cmd.next_mode ? hold_q : lfsr_q;
			rsp_q.cycle_done <= wrapped_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	`LRS_ASSERT_NOW(a_load_into_free_slot, cmd.out_load, !out_valid_q || rsp_ready, "result overwrote an untaken result")
	`LRS_ASSERT_NEXT(a_start_recorded, cmd.skip && status.skip_last && !cmd.next_mode && !cmd.restore, lfsr_q == start_q, "start value not recorded after skip")
	`LRS_ASSERT_NEXT(a_wrap_flag_set, cmd.skip && status.skip_last && cmd.next_mode && adv == start_q, wrapped_q, "return to start value did not raise the cycle flag")

endmodule

/* hdl/lfsr_range_shuffle_unit.sv */
// top level of the lfsr range shuffle unit: controller plus datapath
// depends on lrs_pkg, lrs_ctrl and lrs_datapath
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  req     | in        | req_valid / req_ready   | opcode, restore_value
//  rsp     | out       | rsp_valid / rsp_ready   | number, cycle_done
//  cfg     | in        | cfg_we                  | cfg_index, cfg_data
//
// next runs k lfsr steps in the skip state to land in range (1 to 256, about 2 on
// average) on the single shared lfsr step unit; start and restore run start, width
// search and seed, plus the k skip steps when the masked seed is above size, or only
// start when range_size is zero; opcode 3, or next before any size, goes to result
// arst_n resets the state machine, lfsr and start value to 1, and clears size and cycle flag
// the result register lets a finished result wait while the next request is taken;
// a second result waits in the result state until rsp_ready frees the register
module lfsr_range_shuffle_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_ready,
	input  lrs_pkg::req_t                 req,
	// result channel
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output lrs_pkg::rsp_t                 rsp,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lrs_pkg::DATA_W-1:0]    cfg_data
);
	import lrs_pkg::*;

	// commands from the sequencer, flags back from the datapath
	cmd_t    cmd;
	status_t status;

	// sequencer: walks start, width search, seeding, skip steps and result
	lrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.opcode    (req.opcode),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: config registers, lfsr step, range compare, result register
	lrs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
